>>> src/lpd_pkg.sv
package lpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 15;
  localparam int unsigned HighW = 7;

  localparam logic [LenW-1:0] MaxLenReset = LenW'(16'h1000);
  localparam logic [LenW-1:0] MinTwoByte  = LenW'(8'h80);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_NONMIN  = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_e;

endpackage

>>> src/length_prefix_deframer_unit.sv
// A body byte or a status result is registered and shown in the cycle after its request
// is accepted; a prefix gives one only if empty or in error, bytes after an error none.
// Throughput: one request per cycle, limited only by the single output register
// draining; the input stalls only while that register is full and stalled itself.
// Reset: asynchronous, active low; returns to expecting a first prefix byte, clears
// the sticky error and sets the maximum body length to 4096.
module length_prefix_deframer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lpd_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [lpd_pkg::ByteW-1:0] in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [lpd_pkg::ByteW-1:0] out_byte_o,
  output logic [1:0]                kind_o,
  output logic                      last_o,
  output logic [lpd_pkg::LenW-1:0]  packet_length_o
);
  import lpd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [HighW-1:0]  high_q, high_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [LenW-1:0]   cur_len_q, cur_len_d;
  logic [LenW-1:0]   max_len_q;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  kind_e             out_kind_q;
  logic              out_last_q;
  logic [LenW-1:0]   out_len_q;

  logic              in_fire;
  logic              res_valid;
  logic [ByteW-1:0]  res_byte;
  kind_e             res_kind;
  logic              res_last;
  logic [LenW-1:0]   res_len;
  logic [LenW-1:0]   dec_len;
  logic              two_byte;

  // The output register is the only buffer; a new request is taken whenever it can
  // be emptied in the same cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign two_byte = (phase_q == PH_SECOND);
  assign dec_len  = two_byte ? {high_q, in_byte_i}
                             : {{(LenW-HighW){1'b0}}, in_byte_i[HighW-1:0]};

  always_comb begin
    phase_d   = phase_q;
    high_d    = high_q;
    left_d    = left_q;
    cur_len_d = cur_len_q;
    res_valid = 1'b0;
    res_byte  = '0;
    res_kind  = KIND_BODY;
    res_last  = 1'b0;
    res_len   = '0;
    if (in_fire) begin
      unique case (phase_q)
        PH_FIRST, PH_SECOND: begin
          if (phase_q == PH_FIRST && in_byte_i[ByteW-1]) begin
            high_d  = in_byte_i[HighW-1:0];
            phase_d = PH_SECOND;
          end else if (two_byte && dec_len < MinTwoByte) begin
            phase_d   = PH_STOP;
            res_valid = 1'b1;
            res_kind  = KIND_NONMIN;
            res_len   = dec_len;
          end else if (dec_len > max_len_q) begin
            phase_d   = PH_STOP;
            res_valid = 1'b1;
            res_kind  = KIND_TOOLONG;
            res_len   = dec_len;
          end else if (dec_len == '0) begin
            cur_len_d = '0;
            left_d    = '0;
            phase_d   = PH_FIRST;
            res_valid = 1'b1;
            res_kind  = KIND_EMPTY;
            res_last  = 1'b1;
          end else begin
            cur_len_d = dec_len;
            left_d    = dec_len;
            phase_d   = PH_BODY;
          end
        end
        PH_BODY: begin
          res_valid = 1'b1;
          res_byte  = in_byte_i;
          res_kind  = KIND_BODY;
          res_len   = cur_len_q;
          res_last  = (left_q <= LenW'(1));
          if (res_last) begin
            left_d  = '0;
            phase_d = PH_FIRST;
          end else begin
            left_d = left_q - LenW'(1);
          end
        end
        PH_STOP: begin
          phase_d = PH_STOP;
        end
        default: begin
          phase_d = PH_STOP;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      high_q      <= '0;
      left_q      <= '0;
      cur_len_q   <= '0;
      max_len_q   <= MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      high_q      <= high_d;
      left_q      <= left_d;
      cur_len_q   <= cur_len_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
      out_len_q  <= res_len;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign kind_o          = out_kind_q;
  assign last_o          = out_last_q;
  assign packet_length_o = out_len_q;

  // An error stops the deframer until reset.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOP |=> phase_q == PH_STOP)
    else $error("deframer left the stopped state");

  a_error_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid && (res_kind == KIND_NONMIN || res_kind == KIND_TOOLONG))
    |=> phase_q == PH_STOP)
    else $error("error reported without stopping");

  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> (left_q != '0 && left_q <= cur_len_q))
    else $error("body byte count out of range");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_EMPTY) |-> (out_last_q && out_len_q == '0))
    else $error("malformed empty packet result");

endmodule
